// File: hdl/ggvc_pkg.sv
// Package for the go-to-goal velocity controller: widths, codes, gain
// constants, the CORDIC arctangent table and the speed limiter function.
// No dependencies.
`timescale 1ns / 1ps

package ggvc_pkg;

   localparam int CORDIC_STEPS_DEF = 16;

   // field widths
   localparam int COORD_W    = 24;
   localparam int DELTA_W    = 25;
   localparam int HEAD_W     = 16;
   localparam int RANGE_W    = 16;
   localparam int CMD_W      = 16;
   localparam int LIM_W      = 15;
   localparam int TOL_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // datapath widths
   localparam int ANGLE_W = 32;
   localparam int CXY_W   = 28;
   localparam int MUL_A_W = 27;
   localparam int MUL_B_W = 17;
   localparam int FRAC_W  = 16;
   localparam int WANT_W  = MUL_A_W + MUL_B_W + 1 - FRAC_W;

   // Q16 gains: 1/K of the CORDIC, 0.8 rad scaled to binary angle, 0.3 scaled
   localparam logic [MUL_B_W-1:0] K_INV_GAIN = 17'd39797;
   localparam logic [MUL_B_W-1:0] K_ANG_GAIN = 17'd20588;
   localparam logic [MUL_B_W-1:0] K_LIN_GAIN = 17'd78643;

   // half a turn as start angle for a vector in the left half plane
   localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;
   localparam logic [ANGLE_W-1:0] ROUND_16  = 32'h0000_8000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANG_LIMIT,
      CSR_ANG_STEP,
      CSR_LIN_LIMIT,
      CSR_LIN_STEP,
      CSR_ARRIVE_TOL,
      CSR_OBST_MARGIN,
      CSR_HEAD_TOL
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_MDIST,
      ST_MANG,
      ST_MLIN,
      ST_LIMIT,
      ST_FIN
   } state_type;

   // arctan(2^-i) with 2^32 as a full turn
   function automatic logic [ANGLE_W-1:0] atan_entry(input logic [4:0] idx);
      logic [ANGLE_W-1:0] v;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

   // clamp to +-lim, then clamp the change from prev to +-step
   function automatic logic signed [CMD_W-1:0] limit_speed(
      input logic signed [WANT_W-1:0] want,
      input logic signed [CMD_W-1:0]  prev,
      input logic [LIM_W-1:0]         lim,
      input logic [LIM_W-1:0]         step
   );
      logic signed [WANT_W-1:0]  lim_s;
      logic signed [WANT_W-1:0]  cl;
      logic signed [CMD_W+1:0]   prev_e;
      logic signed [CMD_W+1:0]   step_s;
      logic signed [CMD_W+1:0]   diff;
      logic signed [CMD_W+1:0]   dl;
      logic signed [CMD_W+1:0]   sum;
      lim_s  = $signed({{(WANT_W-LIM_W){1'b0}}, lim});
      if (want > lim_s)
         cl = lim_s;
      else if (want < -lim_s)
         cl = -lim_s;
      else
         cl = want;
      prev_e = $signed({{2{prev[CMD_W-1]}}, prev});
      step_s = $signed({{(CMD_W+2-LIM_W){1'b0}}, step});
      diff   = $signed(cl[CMD_W+1:0]) - prev_e;
      if (diff > step_s)
         dl = step_s;
      else if (diff < -step_s)
         dl = -step_s;
      else
         dl = diff;
      sum = prev_e + dl;
      return sum[CMD_W-1:0];
   endfunction

endpackage

// File: hdl/ggvc_req_if.sv
// Request and response channel interfaces of the go-to-goal controller.
// Depends on ggvc_pkg for the field widths.
`timescale 1ns / 1ps

interface ggvc_req_if;
   import ggvc_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       pose_ok;
   logic signed [COORD_W-1:0]  goal_x;
   logic signed [COORD_W-1:0]  goal_y;
   logic signed [COORD_W-1:0]  robot_x;
   logic signed [COORD_W-1:0]  robot_y;
   logic signed [HEAD_W-1:0]   robot_heading;
   logic                       obstacle_flag;
   logic [RANGE_W-1:0]         obstacle_range;

   modport source (output valid, pose_ok, goal_x, goal_y, robot_x, robot_y,
                   robot_heading, obstacle_flag, obstacle_range, input ready);
   modport sink   (input valid, pose_ok, goal_x, goal_y, robot_x, robot_y,
                   robot_heading, obstacle_flag, obstacle_range, output ready);
endinterface

interface ggvc_rsp_if;
   import ggvc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [CMD_W-1:0]  linear_command;
   logic signed [CMD_W-1:0]  angular_command;

   modport source (output valid, linear_command, angular_command, input ready);
   modport sink   (input valid, linear_command, angular_command, output ready);
endinterface

// File: hdl/ggvc_cordic.sv
// Iterative vectoring CORDIC: one micro-rotation per cycle, gives the
// unscaled magnitude and the binary angle of (dx, dy). Depends on ggvc_pkg.
`timescale 1ns / 1ps

module ggvc_cordic #(
   parameter int STEPS = ggvc_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [ggvc_pkg::DELTA_W-1:0]   dx,
   input  logic signed [ggvc_pkg::DELTA_W-1:0]   dy,
   output logic signed [ggvc_pkg::CXY_W-1:0]     x_out,
   output logic [ggvc_pkg::ANGLE_W-1:0]          z_out,
   output logic                                  done
);
   import ggvc_pkg::*;

   localparam int CNT_W = $clog2(STEPS + 1);

   logic signed [CXY_W-1:0] x_ff, y_ff, x_in, y_in;
   logic [ANGLE_W-1:0]      z_ff, z_in;
   logic [CNT_W-1:0]        step_ff;
   logic                    busy_ff, done_ff;
   logic signed [CXY_W-1:0] xs, ys, dx_e, dy_e;
   logic [ANGLE_W-1:0]      angle;

   assign dx_e = CXY_W'(dx);
   assign dy_e = CXY_W'(dy);

   // one micro-rotation toward the x axis
   always_comb begin
      xs    = x_ff >>> step_ff;
      ys    = y_ff >>> step_ff;
      angle = atan_entry(5'(step_ff));
      if (y_ff >= 0) begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + angle;
      end else begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - angle;
      end
   end

   // control: step counter and done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath: fold the left half plane onto the right at load
   always_ff @(posedge clock) begin
      if (start) begin
         if (dx_e < 0) begin
            x_ff <= -dx_e;
            y_ff <= -dy_e;
            z_ff <= HALF_TURN;
         end else begin
            x_ff <= dx_e;
            y_ff <= dy_e;
            z_ff <= '0;
         end
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_out = x_ff;
   assign z_out = z_ff;
   assign done  = done_ff;

endmodule

// File: hdl/ggvc_serial_mult.sv
// Bit-serial multiplier by a Q16 gain: one multiplier bit per cycle,
// result = floor((a * b + 2^15) / 2^16). Depends on ggvc_pkg.
`timescale 1ns / 1ps

module ggvc_serial_mult (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [ggvc_pkg::MUL_A_W-1:0]   a,
   input  logic [ggvc_pkg::MUL_B_W-1:0]          b,
   output logic signed [ggvc_pkg::WANT_W-1:0]    result,
   output logic                                  done
);
   import ggvc_pkg::*;

   localparam int ACC_W = MUL_A_W + MUL_B_W + 1;
   localparam int CNT_W = $clog2(MUL_B_W + 1);

   logic signed [ACC_W-1:0] acc_ff, mcand_ff;
   logic [MUL_B_W-1:0]      mult_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    busy_ff, done_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_B_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // shift-add, LSB of the multiplier first; accumulator starts at the rounding bias
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff   <= ACC_W'(1) <<< (FRAC_W - 1);
         mcand_ff <= ACC_W'(a);
         mult_ff  <= b;
      end else if (busy_ff) begin
         if (mult_ff[0])
            acc_ff <= acc_ff + mcand_ff;
         mcand_ff <= mcand_ff <<< 1;
         mult_ff  <= mult_ff >> 1;
      end
   end

   assign result = acc_ff[ACC_W-1:FRAC_W];
   assign done   = done_ff;

endmodule

// File: hdl/go_to_goal_velocity_controller.sv
// Go-to-goal velocity controller: one tick in, one pair of speed commands out.
// A valid-pose tick runs the CORDIC and the distance, angular and linear multiplies, the
//   last skipped when forward motion is held or the clipped distance is within arrival
//   tolerance; a tick without a valid pose skips all. One tick at a time: the next is
//   accepted once the result is presented. Time per tick is set by the one-step-per-cycle
//   CORDIC and the shared bit-serial multiplier, used up to three times. Reset (synchronous)
//   restores the register defaults and clears the stored speeds.
`timescale 1ns / 1ps

module go_to_goal_velocity_controller #(
   parameter int CORDIC_STEPS = ggvc_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   ggvc_req_if.sink                            req_bus,
   ggvc_rsp_if.source                          rsp_bus,
   input  logic                                csr_write_enable,
   input  logic [ggvc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ggvc_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import ggvc_pkg::*;

   // configuration registers
   logic [LIM_W-1:0] ang_limit_ff, ang_step_ff, lin_limit_ff, lin_step_ff, head_tol_ff;
   logic [TOL_W-1:0] arrive_tol_ff, obst_margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_limit_ff   <= 15'd6144;
         ang_step_ff    <= 15'd410;
         lin_limit_ff   <= 15'd1024;
         lin_step_ff    <= 15'd164;
         arrive_tol_ff  <= 16'd51;
         obst_margin_ff <= 16'd307;
         head_tol_ff    <= 15'd2086;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ANG_LIMIT:   ang_limit_ff   <= csr_write_data[LIM_W-1:0];
            CSR_ANG_STEP:    ang_step_ff    <= csr_write_data[LIM_W-1:0];
            CSR_LIN_LIMIT:   lin_limit_ff   <= csr_write_data[LIM_W-1:0];
            CSR_LIN_STEP:    lin_step_ff    <= csr_write_data[LIM_W-1:0];
            CSR_ARRIVE_TOL:  arrive_tol_ff  <= csr_write_data;
            CSR_OBST_MARGIN: obst_margin_ff <= csr_write_data;
            CSR_HEAD_TOL:    head_tol_ff    <= csr_write_data[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   state_type state_ff, state_in;

   logic signed [CMD_W-1:0]   last_lin_ff, last_ang_ff;
   logic signed [CMD_W-1:0]   out_lin_ff, out_ang_ff;
   logic                      rsp_valid_ff;
   logic signed [HEAD_W-1:0]  heading_ff;
   logic                      obst_flag_ff;
   logic [RANGE_W-1:0]        obst_range_ff;
   logic                      zero_vec_ff;
   logic signed [WANT_W-1:0]  dist_ff, want_ang_ff, want_lin_ff;
   logic signed [HEAD_W-1:0]  err_ff;

   // sub-unit hookup
   logic                       accept, pose_fail;
   logic                       cord_start, cord_done;
   logic signed [DELTA_W-1:0]  dx, dy;
   logic signed [CXY_W-1:0]    cord_x;
   logic [ANGLE_W-1:0]         cord_z;
   logic                       mul_start, mul_done;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]         mul_b;
   logic signed [WANT_W-1:0]   mul_res;

   // post-processing terms
   logic [ANGLE_W-1:0]         z_round;
   logic [HEAD_W-1:0]          bearing;
   logic signed [HEAD_W-1:0]   err_new;
   logic [HEAD_W:0]            abs_err;
   logic signed [RANGE_W:0]    room_raw;
   logic signed [WANT_W-1:0]   room, d_sel, tol_s;
   logic                       lin_hold, rsp_free;
   logic signed [CMD_W-1:0]    lin_new, ang_new;

   assign accept    = req_bus.valid && req_bus.ready;
   assign pose_fail = !req_bus.pose_ok;
   assign dx = DELTA_W'(req_bus.goal_x) - DELTA_W'(req_bus.robot_x);
   assign dy = DELTA_W'(req_bus.goal_y) - DELTA_W'(req_bus.robot_y);
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign tol_s    = $signed({{(WANT_W-TOL_W){1'b0}}, arrive_tol_ff});

   // bearing and heading error from the CORDIC angle, forward hold, obstacle room, limited speeds
   always_comb begin
      z_round  = zero_vec_ff ? '0 : (cord_z + ROUND_16);
      bearing  = z_round[ANGLE_W-1:ANGLE_W-HEAD_W];
      err_new  = $signed(bearing - heading_ff);
      abs_err  = err_ff[HEAD_W-1] ? (HEAD_W+1)'(-$signed({err_ff[HEAD_W-1], err_ff}))
                                  : {1'b0, err_ff};
      lin_hold = abs_err > {2'b00, head_tol_ff};
      room_raw = $signed({1'b0, obst_range_ff}) - $signed({1'b0, obst_margin_ff});
      room     = room_raw < 0 ? '0 : WANT_W'(room_raw);
      d_sel    = (obst_flag_ff && dist_ff > room) ? room : dist_ff;
      lin_new  = limit_speed(want_lin_ff, last_lin_ff, lin_limit_ff, lin_step_ff);
      ang_new  = limit_speed(want_ang_ff, last_ang_ff, ang_limit_ff, ang_step_ff);
   end

   // sequencer: next state and unit starts
   always_comb begin
      state_in   = state_ff;
      cord_start = 1'b0;
      mul_start  = 1'b0;
      mul_a      = '0;
      mul_b      = K_INV_GAIN;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (pose_fail) begin
                  state_in = ST_FIN;
               end else begin
                  cord_start = 1'b1;
                  state_in   = ST_CORDIC;
               end
            end
         end
         ST_CORDIC: begin
            if (cord_done) begin
               mul_start = 1'b1;
               mul_a     = cord_x[MUL_A_W-1:0];
               mul_b     = K_INV_GAIN;
               state_in  = ST_MDIST;
            end
         end
         ST_MDIST: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = MUL_A_W'(err_new);
               mul_b     = K_ANG_GAIN;
               state_in  = ST_MANG;
            end
         end
         ST_MANG: begin
            if (mul_done) begin
               if (!lin_hold && d_sel > tol_s) begin
                  mul_start = 1'b1;
                  mul_a     = d_sel[MUL_A_W-1:0];
                  mul_b     = K_LIN_GAIN;
                  state_in  = ST_MLIN;
               end else begin
                  state_in = ST_LIMIT;
               end
            end
         end
         ST_MLIN: begin
            if (mul_done)
               state_in = ST_LIMIT;
         end
         ST_LIMIT: state_in = ST_FIN;
         ST_FIN: begin
            if (rsp_free)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_lin_ff  <= '0;
         last_ang_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_FIN && rsp_free)
            rsp_valid_ff <= 1'b1;
         else if (rsp_bus.ready)
            rsp_valid_ff <= 1'b0;
         if (state_ff == ST_IDLE && accept && pose_fail) begin
            last_lin_ff <= '0;
            last_ang_ff <= '0;
         end else if (state_ff == ST_LIMIT) begin
            last_lin_ff <= lin_new;
            last_ang_ff <= ang_new;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && accept) begin
         heading_ff    <= req_bus.robot_heading;
         obst_flag_ff  <= req_bus.obstacle_flag;
         obst_range_ff <= req_bus.obstacle_range;
         zero_vec_ff   <= (dx == '0) && (dy == '0);
      end
      if (state_ff == ST_MDIST && mul_done) begin
         dist_ff <= mul_res;
         err_ff  <= err_new;
      end
      if (state_ff == ST_MANG && mul_done) begin
         want_ang_ff <= (dist_ff > tol_s) ? mul_res : '0;
         want_lin_ff <= '0;
      end
      if (state_ff == ST_MLIN && mul_done)
         want_lin_ff <= mul_res;
      if (state_ff == ST_FIN && rsp_free) begin
         out_lin_ff <= last_lin_ff;
         out_ang_ff <= last_ang_ff;
      end
   end

   ggvc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cord_start),
      .dx    (dx),
      .dy    (dy),
      .x_out (cord_x),
      .z_out (cord_z),
      .done  (cord_done)
   );

   ggvc_serial_mult u_mult (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .result (mul_res),
      .done   (mul_done)
   );

   assign req_bus.ready           = (state_ff == ST_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.linear_command  = out_lin_ff;
   assign rsp_bus.angular_command = out_ang_ff;

   // a tick without a valid pose clears the stored speeds
   a_pose_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && accept && pose_fail) |=> (last_lin_ff == 0 && last_ang_ff == 0))
      else $error("stored speeds not cleared on invalid pose");

   // CORDIC only finishes while the sequencer waits for it
   a_cord_done: assert property (@(posedge clock) disable iff (reset)
      cord_done |-> (state_ff == ST_CORDIC))
      else $error("CORDIC done outside its state");

   // the multiplier only finishes in a multiply state
   a_mul_done: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MDIST || state_ff == ST_MANG || state_ff == ST_MLIN))
      else $error("multiplier done outside a multiply state");

   // leaving the final state always presents a result
   a_fin_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_free) |=> rsp_valid_ff)
      else $error("result not presented");

endmodule

// File: dv/tb_go_to_goal_velocity_controller.sv
// Testbench for the go-to-goal velocity controller: directed table, then random ticks,
// all checked against an in-bench predictor of the CORDIC and speed laws.
// Depends on ggvc_pkg, the channel interfaces in hdl/ggvc_req_if.sv and the controller.
`timescale 1ns / 1ps

module tb_go_to_goal_velocity_controller;
   import ggvc_pkg::*;

   localparam int N_RANDOM = 1450;

   typedef struct packed {
      logic                      pose_ok;
      logic signed [COORD_W-1:0] goal_x;
      logic signed [COORD_W-1:0] goal_y;
      logic signed [COORD_W-1:0] robot_x;
      logic signed [COORD_W-1:0] robot_y;
      logic signed [HEAD_W-1:0]  robot_heading;
      logic                      obstacle_flag;
      logic [RANGE_W-1:0]        obstacle_range;
   } tick_t;

   localparam int TICK_W = $bits(tick_t);

   typedef struct packed {
      logic signed [CMD_W-1:0] linear_command;
      logic signed [CMD_W-1:0] angular_command;
   } cmd_t;

   // directed row: tick plus optional typed-in commands
   typedef struct {
      tick_t tick;
      bit    known;
      cmd_t  cmd;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   ggvc_req_if req_bus ();
   ggvc_rsp_if rsp_bus ();

   go_to_goal_velocity_controller dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // predictor state and registers
   longint ang_lim, ang_step, lin_lim, lin_step, arrive_tol, obst_margin, head_tol;
   longint prev_lin, prev_ang;
   cmd_t   cmd_queue[$];
   bit     cmd_known[$];
   cmd_t   cmd_typed[$];
   int     fails = 0;
   int     send_idle = 11, recv_idle = 62;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("simulation failed");
      $finish;
   end

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint slew(longint want, longint prev, longint lim, longint stp);
      longint w;
      w = clip(want, -lim, lim);
      return prev + clip(w - prev, -stp, stp);
   endfunction

   // work out the commands for one tick and advance the stored speeds
   function automatic cmd_t steer_tick(tick_t t);
      longint dx, dy, x, y, xs, ys, dist_q, d, err, aerr, want_a, want_l, room;
      logic [31:0] z;
      logic [15:0] bearing;
      cmd_t c;
      if (!t.pose_ok) begin
         prev_lin = 0;
         prev_ang = 0;
         return '0;
      end
      dx = longint'(t.goal_x) - longint'(t.robot_x);
      dy = longint'(t.goal_y) - longint'(t.robot_y);
      x = dx; y = dy; z = 0;
      if (x < 0) begin
         x = -x; y = -y; z = HALF_TURN;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         xs = x >>> i; ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + atan_entry(5'(i));
         end else begin
            x = x - ys; y = y + xs; z = z - atan_entry(5'(i));
         end
      end
      if (dx == 0 && dy == 0) z = 0;
      dist_q = (x * 39797 + 32768) >>> 16;
      bearing = 16'((33'(z) + 33'h8000) >> 16);
      err = longint'($signed(16'(bearing - t.robot_heading)));
      aerr = err < 0 ? -err : err;
      want_a = dist_q > arrive_tol ? (err * 20588 + 32768) >>> 16 : 0;
      if (aerr > head_tol) want_l = 0;
      else begin
         d = dist_q;
         if (t.obstacle_flag) begin
            room = longint'(t.obstacle_range) - obst_margin;
            if (room < 0) room = 0;
            if (d > room) d = room;
         end
         want_l = d > arrive_tol ? (d * 78643 + 32768) >>> 16 : 0;
      end
      prev_ang = slew(want_a, prev_ang, ang_lim, ang_step);
      prev_lin = slew(want_l, prev_lin, lin_lim, lin_step);
      c.linear_command = 16'(prev_lin);
      c.angular_command = 16'(prev_ang);
      return c;
   endfunction

   task automatic write_reg(csr_index_type idx, int value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= 16'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_ANG_LIMIT:   ang_lim = value & 16'h7FFF;
         CSR_ANG_STEP:    ang_step = value & 16'h7FFF;
         CSR_LIN_LIMIT:   lin_lim = value & 16'h7FFF;
         CSR_LIN_STEP:    lin_step = value & 16'h7FFF;
         CSR_ARRIVE_TOL:  arrive_tol = value & 16'hFFFF;
         CSR_OBST_MARGIN: obst_margin = value & 16'hFFFF;
         CSR_HEAD_TOL:    head_tol = value & 16'h7FFF;
         default: ;
      endcase
   endtask

   task automatic write_all(int al, int ast, int ll, int lst, int at, int om, int ht);
      write_reg(CSR_ANG_LIMIT, al);
      write_reg(CSR_ANG_STEP, ast);
      write_reg(CSR_LIN_LIMIT, ll);
      write_reg(CSR_LIN_STEP, lst);
      write_reg(CSR_ARRIVE_TOL, at);
      write_reg(CSR_OBST_MARGIN, om);
      write_reg(CSR_HEAD_TOL, ht);
   endtask

   // wait until every command has come back, then past the tick latency
   task automatic drain();
      while (cmd_queue.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   // drive one tick at a later falling edge, hold until its transfer
   task automatic send_tick(tick_t t, bit known, cmd_t typed);
      do @(negedge clock); while ($urandom_range(99) < send_idle);
      req_bus.valid <= 1'b1;
      {req_bus.pose_ok, req_bus.goal_x, req_bus.goal_y, req_bus.robot_x, req_bus.robot_y,
       req_bus.robot_heading, req_bus.obstacle_flag, req_bus.obstacle_range} <= t;
      do @(posedge clock); while (!req_bus.ready);
      cmd_queue.push_back(steer_tick(t));
      cmd_known.push_back(known);
      cmd_typed.push_back(typed);
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   function automatic tick_t rand_tick();
      tick_t t;
      int span;
      t = TICK_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
      t.pose_ok = $urandom_range(15) != 0;
      // mostly goals near the robot so the laws leave saturation
      if ($urandom_range(3) != 0) begin
         span = 1 << $urandom_range(16, 2);
         t.goal_x = COORD_W'(t.robot_x + $signed($urandom_range(2 * span) - span));
         t.goal_y = COORD_W'(t.robot_y + $signed($urandom_range(2 * span) - span));
      end
      if ($urandom_range(1)) t.robot_heading = HEAD_W'($signed($urandom_range(4000)) - 2000);
      return t;
   endfunction

   // response side: random stall, compare at the rising edge
   initial begin
      cmd_t exp_c, act;
      bit known;
      cmd_t typed;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle);
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            act.linear_command = rsp_bus.linear_command;
            act.angular_command = rsp_bus.angular_command;
            if (cmd_queue.size() == 0) begin
               $error("command transfer with nothing expected");
               fails++;
            end else begin
               exp_c = cmd_queue.pop_front();
               known = cmd_known.pop_front();
               typed = cmd_typed.pop_front();
               if (known && typed != exp_c) begin
                  $error("typed row disagrees with predictor");
                  fails++;
               end
               if (act.linear_command !== exp_c.linear_command) begin
                  $error("linear_command expected %0d got %0d",
                         exp_c.linear_command, act.linear_command);
                  fails++;
               end
               if (act.angular_command !== exp_c.angular_command) begin
                  $error("angular_command expected %0d got %0d",
                         exp_c.angular_command, act.angular_command);
                  fails++;
               end
            end
         end
      end
   end

   initial begin
      row_t rows[$];
      row_t r;
      tick_t t;
      req_bus.valid = 1'b0;
      {req_bus.pose_ok, req_bus.goal_x, req_bus.goal_y, req_bus.robot_x, req_bus.robot_y,
       req_bus.robot_heading, req_bus.obstacle_flag, req_bus.obstacle_range} = '0;
      ang_lim = 6144; ang_step = 410; lin_lim = 1024; lin_step = 164;
      arrive_tol = 51; obst_margin = 307; head_tol = 2086;
      prev_lin = 0; prev_ang = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      t = '0;
      r.tick = t; r.known = 1; r.cmd = '0; rows.push_back(r);           // invalid pose
      t.pose_ok = 1;
      r.tick = t; r.known = 1; r.cmd = '0; rows.push_back(r);           // goal on robot
      r.known = 0;
      t.goal_x = 24'sd10240; r.tick = t; rows.push_back(r);             // straight ahead
      rows.push_back(r);
      t.obstacle_flag = 1; t.obstacle_range = 400; r.tick = t; rows.push_back(r);
      t.obstacle_range = 0; r.tick = t; rows.push_back(r);
      t.obstacle_range = 16'hFFFF; r.tick = t; rows.push_back(r);
      t.obstacle_flag = 0;
      t.goal_x = 24'sh7FFFFF; t.robot_x = 24'sh800000; r.tick = t; rows.push_back(r);
      t.goal_y = 24'sh7FFFFF; t.robot_y = 24'sh800000; r.tick = t; rows.push_back(r);
      t.goal_x = 24'sh800000; t.robot_x = 24'sh7FFFFF; r.tick = t; rows.push_back(r);
      t.goal_y = 24'sh800000; t.robot_y = 24'sh7FFFFF; r.tick = t; rows.push_back(r);
      t.robot_heading = 16'sh7FFF; r.tick = t; rows.push_back(r);
      t.robot_heading = 16'sh8000; r.tick = t; rows.push_back(r);
      t = '0; t.pose_ok = 1; t.goal_x = -24'sd5000; r.tick = t; rows.push_back(r);
      t.goal_y = 24'sd3; r.tick = t; rows.push_back(r);
      t.goal_y = -24'sd3; r.tick = t; rows.push_back(r);
      t.goal_x = 24'sd20; t.goal_y = 0; r.tick = t; rows.push_back(r); // inside arrival
      t = '1; t.pose_ok = 0; r.tick = t; r.known = 1; rows.push_back(r);
      foreach (rows[i]) send_tick(rows[i].tick, rows[i].known, rows[i].cmd);
      drain();

      // zero limits then extremes, then back to defaults
      write_all(0, 0, 0, 0, 0, 0, 0);
      for (int i = 0; i < 4; i++) send_tick(rand_tick(), 0, '0);
      drain();
      write_all(32767, 32767, 32767, 32767, 65535, 65535, 32767);
      for (int i = 0; i < 4; i++) send_tick(rand_tick(), 0, '0);
      drain();
      write_all(32767, 32767, 32767, 32767, 0, 0, 32767);
      for (int i = 0; i < 4; i++) send_tick(rand_tick(), 0, '0);
      drain();
      write_reg(csr_index_type'(7), 16'h1234);   // unused index is ignored
      write_all(6144, 410, 1024, 164, 51, 307, 2086);

      // random phases: idling mix swaps, then idling is off, config varies between chunks
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 2) begin send_idle = 62; recv_idle = 11; end
         if (ph == 4) begin send_idle = 0; recv_idle = 0; end
         for (int i = 0; i < N_RANDOM / 6; i++) begin
            send_tick(rand_tick(), 0, '0);
         end
         drain();
         write_all($urandom_range(32767), $urandom_range(2000), $urandom_range(32767),
                   $urandom_range(2000), $urandom_range(300), $urandom_range(2000),
                   $urandom_range(32767));
      end
      drain();
      if (fails == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
